FILE: sv/fsd_pkg.sv
package fsd_pkg;

    // field widths
    localparam int TICK_W  = 48;
    localparam int DTICK_W = 32;
    localparam int NUM_W   = 16;
    localparam int DEN_W   = 20;
    localparam int US_W    = 62;
    localparam int DUR_W   = 20;
    localparam int GAP_W   = 27;
    localparam int MCLK_W  = 48;
    localparam int CFG_W   = 27;
    localparam int IDX_W   = 3;
    localparam int ACT_W   = 2;

    // conversion datapath: ticks * num, then * 1e6, then / den
    localparam int PROD_W  = TICK_W + NUM_W;
    localparam int SCALE_W = 20;
    localparam int ACC_W   = PROD_W + SCALE_W;
    localparam int CNT_W   = 7;
    localparam int DELAY_W = 64;

    localparam logic [SCALE_W-1:0] US_PER_S = SCALE_W'(1000000);
    localparam logic [US_W-1:0]    PTS_MAX  = '1;
    localparam logic [DUR_W-1:0]   DUR_MAX  = '1;

    // actions
    localparam logic [ACT_W-1:0] ACT_SHOW = 2'd0;
    localparam logic [ACT_W-1:0] ACT_WAIT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DROP = 2'd2;

    // register indexes
    localparam logic [IDX_W-1:0] CFG_TB_NUM   = 3'd0;
    localparam logic [IDX_W-1:0] CFG_TB_DEN   = 3'd1;
    localparam logic [IDX_W-1:0] CFG_DEF_DUR  = 3'd2;
    localparam logic [IDX_W-1:0] CFG_LIVE     = 3'd3;
    localparam logic [IDX_W-1:0] CFG_LIVE_GAP = 3'd4;
    localparam logic [IDX_W-1:0] CFG_FILE_GAP = 3'd5;
    localparam logic [IDX_W-1:0] CFG_SYNC_MIN = 3'd6;
    localparam logic [IDX_W-1:0] CFG_SYNC_MAX = 3'd7;

    // conversion unit status
    typedef struct packed {
        logic done;
        logic ovf;
    } t_conv_stat;

    // per-frame flags for the decision
    typedef struct packed {
        logic first;
        logic clock_unknown;
        logic master_valid;
        logic master_is_audio;
    } t_dec_ctl;

endpackage

FILE: sv/fsd_conv.sv
module fsd_conv import fsd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [TICK_W-1:0] i_ticks,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    output t_conv_stat        o_stat,
    output logic [US_W-1:0]   o_quot
);

    localparam logic [1:0] P_IDLE = 2'd0;
    localparam logic [1:0] P_MUL  = 2'd1;
    localparam logic [1:0] P_DIV  = 2'd2;

    logic [1:0]        r_phase, n_phase;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_done, n_done;
    logic [PROD_W-1:0] r_a;
    logic [ACC_W-1:0]  r_acc, n_acc;
    logic [DEN_W-1:0]  r_rem, n_rem;
    logic [DEN_W-1:0]  r_den;

    logic [DEN_W:0]    w_trial;
    logic              w_ge;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign w_trial = {r_rem, r_acc[ACC_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        n_acc   = r_acc;
        n_rem   = r_rem;
        unique case (r_phase)
            P_IDLE: begin
                if (i_start) begin
                    n_phase = P_MUL;
                    n_cnt   = CNT_W'(SCALE_W - 1);
                    n_acc   = '0;
                end
            end
            P_MUL: begin
                // shift-add over the bits of 1e6, MSB first
                n_acc = {r_acc[ACC_W-2:0], 1'b0}
                      + (US_PER_S[r_cnt[4:0]] ? ACC_W'(r_a) : '0);
                if (r_cnt == '0) begin
                    n_phase = P_DIV;
                    n_cnt   = CNT_W'(ACC_W - 1);
                    n_rem   = '0;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            P_DIV: begin
                n_rem = w_ge ? DEN_W'(w_trial - {1'b0, r_den}) : w_trial[DEN_W-1:0];
                n_acc = {r_acc[ACC_W-2:0], w_ge};
                if (r_cnt == '0) begin
                    n_phase = P_IDLE;
                    n_done  = 1'b1;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            default: n_phase = P_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= n_done;
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_acc <= n_acc;
        r_rem <= n_rem;
        if (r_phase == P_IDLE && i_start) begin
            r_a   <= PROD_W'(i_ticks) * PROD_W'(i_num);
            r_den <= (i_den == '0) ? DEN_W'(1) : i_den;
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.ovf  = |r_acc[ACC_W-1:US_W];
    assign o_quot      = r_acc[US_W-1:0];

endmodule

FILE: sv/fsd_decide.sv
module fsd_decide import fsd_pkg::*; (
    input  logic signed [DELAY_W-1:0] i_delay,
    input  t_dec_ctl                  i_ctl,
    input  logic [GAP_W-1:0]          i_gap_thr,
    input  logic [DUR_W-1:0]          i_sync_min,
    input  logic [DUR_W-1:0]          i_sync_max,
    output logic [ACT_W-1:0]          o_action,
    output logic [DUR_W-1:0]          o_wait,
    output logic                      o_resync
);

    logic [DELAY_W-1:0]        w_mag;
    logic signed [DELAY_W-1:0] w_neg_max;
    logic                      w_gap;
    logic                      w_drop;
    logic                      w_neg;
    logic                      w_below_min;
    logic                      w_above_max;

    // magnitude and threshold compares on the signed delay
    assign w_mag       = i_delay[DELAY_W-1] ? DELAY_W'(-i_delay) : DELAY_W'(i_delay);
    assign w_neg_max   = -$signed(DELAY_W'(i_sync_max));
    assign w_gap       = (w_mag > DELAY_W'(i_gap_thr));
    assign w_drop      = (i_delay < w_neg_max);
    assign w_neg       = i_delay[DELAY_W-1];
    assign w_below_min = (i_delay < $signed(DELAY_W'(i_sync_min)));
    assign w_above_max = (i_delay > $signed(DELAY_W'(i_sync_max)));

    always_comb begin
        o_action = ACT_SHOW;
        o_wait   = '0;
        o_resync = 1'b0;
        priority if (i_ctl.first) begin
            o_resync = i_ctl.clock_unknown;
        end else if (i_ctl.clock_unknown) begin
            o_resync = 1'b1;
        end else if (!i_ctl.master_valid) begin
            o_resync = 1'b0;
        end else if (w_gap && !i_ctl.master_is_audio) begin
            o_resync = 1'b1;
        end else if (w_drop) begin
            o_action = ACT_DROP;
        end else if (w_neg || w_below_min) begin
            o_action = ACT_SHOW;
        end else if (w_above_max) begin
            o_action = ACT_WAIT;
            o_wait   = i_sync_max;
        end else begin
            o_action = ACT_WAIT;
            o_wait   = i_delay[DUR_W-1:0];
        end
    end

endmodule

FILE: sv/frame_sync_decision_core.sv
// Video frame sync decision core.
// Input channel (i_in_valid / o_in_ready): one beat per frame or flush item.
// Output channel (o_out_valid / i_out_ready): one beat per frame item with
// action, delay_us, video_clock_us and resync_request. Flush gives no beat.
// Config port (i_cfg_we, i_cfg_index, i_cfg_wdata): single-cycle writes, to be
// made only while the core is idle; the core itself does not enforce this.
// A frame takes one item at a time. Each valid timestamp and each nonzero
// duration in ticks goes through the shared serial converter: a shift-add
// multiply (x 1e6) and then a restoring divide (/ time_base_den).
// A frame steps through S_PTS, S_PTS_W, S_DUR, S_DUR_W, S_DELAY and S_DECIDE,
// skipping the wait state of a field that is not converted; a flush is
// handled in S_IDLE. The next item can be accepted in the cycle after the
// result is registered.
// o_in_ready is high only while the sequencer is idle. A finished result
// waits in the output register; the next item may be accepted meanwhile,
// but its result is held back until the receiver has taken the previous one.
// Reset (synchronous, active low) loads the default registers, resets the
// stream state and clears the output valid.
module frame_sync_decision_core import fsd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input channel
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_operation,
    input  logic [TICK_W-1:0]        i_pts_ticks,
    input  logic                     i_pts_valid,
    input  logic [DTICK_W-1:0]       i_duration_ticks,
    input  logic signed [MCLK_W-1:0] i_master_clock_us,
    input  logic                     i_master_clock_valid,
    input  logic                     i_clock_unknown,
    input  logic                     i_master_is_audio,
    // output channel
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [ACT_W-1:0]         o_action,
    output logic [DUR_W-1:0]         o_delay_us,
    output logic [US_W-1:0]          o_video_clock_us,
    output logic                     o_resync_request,
    // config port
    input  logic                     i_cfg_we,
    input  logic [IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_wdata
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PTS    = 3'd1;
    localparam logic [2:0] S_PTS_W  = 3'd2;
    localparam logic [2:0] S_DUR    = 3'd3;
    localparam logic [2:0] S_DUR_W  = 3'd4;
    localparam logic [2:0] S_DELAY  = 3'd5;
    localparam logic [2:0] S_DECIDE = 3'd6;

    // config registers
    logic [NUM_W-1:0] r_tb_num;
    logic [DEN_W-1:0] r_tb_den;
    logic [DUR_W-1:0] r_def_dur;
    logic             r_live;
    logic [GAP_W-1:0] r_live_gap;
    logic [GAP_W-1:0] r_file_gap;
    logic [DUR_W-1:0] r_sync_min;
    logic [DUR_W-1:0] r_sync_max;

    // stream state
    logic [US_W-1:0]  r_last_pts;
    logic [DUR_W-1:0] r_last_dur;
    logic             r_first;

    // sequencer and latched item
    logic [2:0]              r_state, n_state;
    logic [TICK_W-1:0]       r_pts_ticks;
    logic                    r_pts_valid;
    logic [DTICK_W-1:0]      r_dur_ticks;
    logic [MCLK_W-1:0]       r_master;
    t_dec_ctl                r_ctl;
    logic [US_W-1:0]         r_pts;
    logic [DUR_W-1:0]        r_dur;
    logic signed [DELAY_W-1:0] r_delay;

    // output register
    logic             r_out_valid;
    logic [ACT_W-1:0] r_action;
    logic [DUR_W-1:0] r_delay_us;
    logic [US_W-1:0]  r_vclk;
    logic             r_resync;

    logic             w_in_acc;
    logic             w_out_free;
    logic             w_conv_start;
    logic [TICK_W-1:0] w_conv_ticks;
    t_conv_stat       w_conv_stat;
    logic [US_W-1:0]  w_conv_quot;
    logic [US_W:0]    w_est;
    logic [ACT_W-1:0] w_action;
    logic [DUR_W-1:0] w_wait;
    logic             w_resync;
    t_dec_ctl         w_ctl;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // shared converter, fed either timestamp or duration ticks
    assign w_conv_start = (r_state == S_PTS && r_pts_valid)
                       || (r_state == S_DUR && r_dur_ticks != '0);
    assign w_conv_ticks = (r_state == S_PTS) ? r_pts_ticks : TICK_W'(r_dur_ticks);

    fsd_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_conv_start),
        .i_ticks (w_conv_ticks),
        .i_num   (r_tb_num),
        .i_den   (r_tb_den),
        .o_stat  (w_conv_stat),
        .o_quot  (w_conv_quot)
    );

    // estimate for a frame without timestamp, saturating
    assign w_est = {1'b0, r_last_pts} + (US_W + 1)'(r_last_dur);

    assign w_ctl.first           = r_first;
    assign w_ctl.clock_unknown   = r_ctl.clock_unknown;
    assign w_ctl.master_valid    = r_ctl.master_valid;
    assign w_ctl.master_is_audio = r_ctl.master_is_audio;

    fsd_decide u_decide (
        .i_delay    (r_delay),
        .i_ctl      (w_ctl),
        .i_gap_thr  (r_live ? r_live_gap : r_file_gap),
        .i_sync_min (r_sync_min),
        .i_sync_max (r_sync_max),
        .o_action   (w_action),
        .o_wait     (w_wait),
        .o_resync   (w_resync)
    );

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (w_in_acc && !i_operation) n_state = S_PTS;
            S_PTS:    n_state = r_pts_valid ? S_PTS_W : S_DUR;
            S_PTS_W:  if (w_conv_stat.done) n_state = S_DUR;
            S_DUR:    n_state = (r_dur_ticks != '0) ? S_DUR_W : S_DELAY;
            S_DUR_W:  if (w_conv_stat.done) n_state = S_DELAY;
            S_DELAY:  n_state = S_DECIDE;
            S_DECIDE: if (w_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // control state, config and stream state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_tb_num    <= NUM_W'(1);
            r_tb_den    <= DEN_W'(90000);
            r_def_dur   <= DUR_W'(40000);
            r_live      <= 1'b0;
            r_live_gap  <= GAP_W'(1000000);
            r_file_gap  <= GAP_W'(10000000);
            r_sync_min  <= DUR_W'(40000);
            r_sync_max  <= DUR_W'(100000);
            r_last_pts  <= '0;
            r_last_dur  <= DUR_W'(40000);
            r_first     <= 1'b0;
        end else begin
            r_state <= n_state;

            // new beat loaded, else drop valid once taken
            if (r_state == S_DECIDE && w_out_free) r_out_valid <= 1'b1;
            else if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_TB_NUM:   r_tb_num   <= i_cfg_wdata[NUM_W-1:0];
                    CFG_TB_DEN:   r_tb_den   <= i_cfg_wdata[DEN_W-1:0];
                    CFG_DEF_DUR:  r_def_dur  <= i_cfg_wdata[DUR_W-1:0];
                    CFG_LIVE:     r_live     <= i_cfg_wdata[0];
                    CFG_LIVE_GAP: r_live_gap <= i_cfg_wdata[GAP_W-1:0];
                    CFG_FILE_GAP: r_file_gap <= i_cfg_wdata[GAP_W-1:0];
                    CFG_SYNC_MIN: r_sync_min <= i_cfg_wdata[DUR_W-1:0];
                    CFG_SYNC_MAX: r_sync_max <= i_cfg_wdata[DUR_W-1:0];
                    default: ;
                endcase
            end

            // flush restores the stream state at once
            if (w_in_acc && i_operation) begin
                r_last_pts <= '0;
                r_last_dur <= r_def_dur;
                r_first    <= 1'b1;
            end

            if (r_state == S_DELAY) begin
                r_last_pts <= r_pts;
                r_last_dur <= r_dur;
            end

            if (r_state == S_DECIDE && w_out_free) r_first <= 1'b0;
        end
    end

    // item datapath, no reset
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_pts_ticks         <= i_pts_ticks;
            r_pts_valid         <= i_pts_valid;
            r_dur_ticks         <= i_duration_ticks;
            r_master            <= i_master_clock_us;
            r_ctl.first         <= 1'b0;
            r_ctl.clock_unknown <= i_clock_unknown;
            r_ctl.master_valid  <= i_master_clock_valid;
            r_ctl.master_is_audio <= i_master_is_audio;
        end

        if (r_state == S_PTS && !r_pts_valid) begin
            r_pts <= w_est[US_W] ? PTS_MAX : w_est[US_W-1:0];
        end
        if (r_state == S_PTS_W && w_conv_stat.done) begin
            r_pts <= w_conv_stat.ovf ? PTS_MAX : w_conv_quot;
        end

        if (r_state == S_DUR && r_dur_ticks == '0) begin
            r_dur <= r_last_dur;
        end
        if (r_state == S_DUR_W && w_conv_stat.done) begin
            r_dur <= (w_conv_stat.ovf || (|w_conv_quot[US_W-1:DUR_W]))
                   ? DUR_MAX : w_conv_quot[DUR_W-1:0];
        end

        if (r_state == S_DELAY) begin
            r_delay <= $signed({2'b00, r_pts})
                     - $signed({{(DELAY_W - MCLK_W){r_master[MCLK_W-1]}}, r_master});
        end

        if (r_state == S_DECIDE && w_out_free) begin
            r_action   <= w_action;
            r_delay_us <= w_wait;
            r_vclk     <= r_pts;
            r_resync   <= w_resync;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_action         = r_action;
    assign o_delay_us       = r_delay_us;
    assign o_video_clock_us = r_vclk;
    assign o_resync_request = r_resync;

`ifndef SYNTH
    // converter reports only while the sequencer waits on it
    a_conv_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_conv_stat.done |-> (r_state == S_PTS_W || r_state == S_DUR_W))
        else $error("conversion finished outside a wait state");

    // delay is zero unless the action is a wait
    a_delay_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_action != ACT_WAIT) |-> (o_delay_us == '0))
        else $error("nonzero delay without wait action");

    // a wait never exceeds the clamp
    a_wait_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_action == ACT_WAIT) |-> (o_delay_us <= r_sync_max))
        else $error("wait exceeds sync_max_us");

    // flush arms the first-frame flag
    a_flush_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_operation) |=> r_first)
        else $error("flush did not set the first-frame flag");

    // the converter is not started while a frame is being placed in the output
    a_no_start_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE) |-> !w_conv_start)
        else $error("converter started during decision");
`endif

endmodule
